>>> hw/rtl/cpv_pkg.sv
// Shared types, constants and the CRC step for the calibration page validator.
package cpv_pkg;

  localparam int PAGE_BYTES     = 32;
  localparam int HARMONIC_SLOTS = 6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [11:0] DAY_MASK = 12'h0FFF;
  localparam logic [7:0]  ERASED   = 8'hFF;

  // Byte positions inside a page
  localparam logic [4:0] POS_MAGIC    = 5'd0;
  localparam logic [4:0] POS_HDR_LAST = 5'd5;
  localparam logic [4:0] POS_SLOT0    = 5'd6;
  localparam logic [4:0] POS_CRC_LO   = 5'd30;
  localparam logic [4:0] POS_LAST     = 5'(PAGE_BYTES - 1);

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_CRC      = 3'd1,
    ERR_MAGIC    = 3'd2,
    ERR_VERSION  = 3'd3,
    ERR_ID       = 3'd4,
    ERR_HARMONIC = 3'd5,
    ERR_SLOT     = 3'd6
  } err_t;

  typedef struct packed {
    byte_t expected_magic;
    byte_t expected_layout_version;
    byte_t min_unit_id;
    byte_t max_unit_id;
  } cfg_t;

  typedef struct packed {
    logic        virgin;
    logic        crc_good;
    logic        magic_good;
    logic        version_good;
    logic        fields_good;
    err_t        error_code;
    byte_t       layout_version;
    byte_t       unit_id;
    byte_t       site_id;
    logic [11:0] calibration_day;
    logic [3:0]  harmonic_count;
  } result_t;

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input byte_t b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/cpv_page_track.sv
// Per-page tracking state and the end-of-page evaluation.
module cpv_page_track (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  cpv_pkg::byte_t   data,
  input  cpv_pkg::cfg_t    cfg,
  output logic             page_end,
  output cpv_pkg::result_t result
);
  import cpv_pkg::*;

  logic [4:0]  pos;
  logic [15:0] running_crc;
  logic        all_erased;
  logic        magic_match;
  logic        slot_nonzero;
  byte_t       hdr [5];
  byte_t       stored_crc_low;

  logic [3:0]  nharm;
  logic [4:0]  slot_off;
  logic [2:0]  slot;
  logic        in_slots;
  logic        slot_hit;

  logic [15:0] stored_crc;
  logic        crc_ok, ver_ok, id_ok, nh_ok, layout_ok;
  err_t        err;

  assign nharm    = hdr[4][7:4];
  assign slot_off = pos - POS_SLOT0;
  assign slot     = slot_off[4:2];
  assign in_slots = (pos >= POS_SLOT0) && (pos < POS_CRC_LO);
  assign slot_hit = in_slots && ({1'b0, slot} >= nharm)
                 && (slot < 3'(HARMONIC_SLOTS)) && (data != 8'h00);

  assign page_end = accept && (pos == POS_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      running_crc  <= CRC_INIT;
      all_erased   <= 1'b1;
      magic_match  <= 1'b0;
      slot_nonzero <= 1'b0;
    end else if (accept) begin
      if (pos == POS_LAST) begin
        pos          <= '0;
        running_crc  <= CRC_INIT;
        all_erased   <= 1'b1;
        magic_match  <= 1'b0;
        slot_nonzero <= 1'b0;
      end else begin
        pos <= pos + 5'd1;
        if (data != ERASED) all_erased <= 1'b0;
        if (pos < POS_CRC_LO) running_crc <= crc16_byte(running_crc, data);
        if (pos == POS_MAGIC) magic_match <= (data == cfg.expected_magic);
        if (slot_hit) slot_nonzero <= 1'b1;
      end
    end
  end

  // header bytes 1..5 and CRC low byte, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos != POS_MAGIC && pos <= POS_HDR_LAST) hdr[3'(pos - 5'd1)] <= data;
      if (pos == POS_CRC_LO) stored_crc_low <= data;
    end
  end

  // evaluation on the last byte; data is the CRC high byte here
  assign stored_crc = {data, stored_crc_low};
  assign crc_ok     = (running_crc == stored_crc);
  assign ver_ok     = (hdr[0] == cfg.expected_layout_version);
  assign id_ok      = (hdr[1] >= cfg.min_unit_id) && (hdr[1] <= cfg.max_unit_id);
  assign nh_ok      = (nharm <= 4'(HARMONIC_SLOTS));
  assign layout_ok  = id_ok && nh_ok && !slot_nonzero;

  always_comb begin
    if (!crc_ok)           err = ERR_CRC;
    else if (!magic_match) err = ERR_MAGIC;
    else if (!ver_ok)      err = ERR_VERSION;
    else if (!id_ok)       err = ERR_ID;
    else if (!nh_ok)       err = ERR_HARMONIC;
    else if (!layout_ok)   err = ERR_SLOT;
    else                   err = ERR_OK;
  end

  always_comb begin
    result.virgin          = all_erased && (data == ERASED);
    result.crc_good        = crc_ok;
    result.magic_good      = magic_match;
    result.version_good    = ver_ok;
    result.fields_good     = layout_ok;
    result.error_code      = err;
    result.layout_version  = hdr[0];
    result.unit_id         = hdr[1];
    result.site_id         = hdr[2];
    result.calibration_day = {hdr[4][3:0], hdr[3]} & DAY_MASK;
    result.harmonic_count  = hdr[4][7:4];
  end

endmodule

>>> hw/rtl/calibration_page_validator.sv
// Top level of the calibration page validator: stream ports, config registers, result register.
// Takes a 32-byte calibration page one word (byte) per cycle on the slave stream, pages back
// to back with no framing: the first byte after reset is byte 0 of a page. One result word
// comes out per page, loaded in the cycle after byte 31 is taken. Throughput is one byte per
// clock; it is set by the byte-wide CRC-16 step (poly 0x1021, seed 0xFFFF), which finishes in
// the cycle its byte is taken, and the end-of-page compares, which run from the tracking
// registers and byte 31 straight into the result register. s_tready drops only while a
// result sits in the output register and m_tready is low. Config writes land on the next
// edge with cfg_we high; change them only between pages. Byte 0 is checked against
// expected_magic as it arrives, the version and id ranges at byte 31.
module calibration_page_validator (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] virgin, [1] crc_good, [2] magic_good, [3] version_good, [4] fields_good,
  // [7:5] error_code, [15:8] layout_version, [23:16] unit id, [31:24] site id,
  // [43:32] calibration_day, [47:44] harmonic_count
  output logic [47:0] m_tdata,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import cpv_pkg::*;

  typedef enum logic [1:0] {
    REG_MAGIC   = 2'd0,
    REG_VERSION = 2'd1,
    REG_MIN_ID  = 2'd2,
    REG_MAX_ID  = 2'd3
  } reg_idx_t;

  cfg_t    cfg;
  logic    accept;
  logic    page_end;
  result_t result;
  logic    m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_magic          <= 8'd0;
      cfg.expected_layout_version <= 8'd1;
      cfg.min_unit_id             <= 8'd1;
      cfg.max_unit_id             <= 8'd254;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MAGIC:   cfg.expected_magic          <= cfg_data;
        REG_VERSION: cfg.expected_layout_version <= cfg_data;
        REG_MIN_ID:  cfg.min_unit_id             <= cfg_data;
        REG_MAX_ID:  cfg.max_unit_id             <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register frees up in the same cycle it is read
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  cpv_page_track u_track (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .data     (s_tdata),
    .cfg      (cfg),
    .page_end (page_end),
    .result   (result)
  );

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (page_end)      m_tvalid_next = 1'b1;
    else if (m_tready) m_tvalid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else     m_tvalid <= m_tvalid_next;
  end

  always_ff @(posedge clk) begin
    if (page_end) begin
      m_tdata <= {result.harmonic_count, result.calibration_day, result.site_id,
                  result.unit_id, result.layout_version, result.error_code,
                  result.fields_good, result.version_good, result.magic_good,
                  result.crc_good, result.virgin};
    end
  end

endmodule

>>> hw/rtl/cpv_checker.sv
// Port-level checks for the calibration page validator, bound to the top level.
module cpv_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);
  import cpv_pkg::*;

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed under stall");

  // an empty output register never blocks input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // ok code exactly when all four checks pass
  a_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[7:5] == ERR_OK) ==
                  (m_tdata[1] && m_tdata[2] && m_tdata[3] && m_tdata[4])))
    else $error("error code disagrees with check flags");

  // CRC failure takes priority
  a_crc_first: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> m_tdata[7:5] == ERR_CRC)
    else $error("CRC failure not reported first");

endmodule

bind calibration_page_validator cpv_checker u_cpv_checker (.*);
